// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/isa_pkg.sv =====
// Shared constants and types for the indexed shift array.
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SET    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What one cell does this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/isa_cell.sv =====
// One storage cell of the shift array: holds a word, loads, or takes a neighbour's word.
`timescale 1ns / 1ps
`default_nettype none

module isa_cell (
  input  wire logic                            clk,
  input  wire isa_pkg::cell_ctrl_t             ctrl,
  input  wire logic [isa_pkg::DATA_WIDTH-1:0]  load_data,
  input  wire logic [isa_pkg::DATA_WIDTH-1:0]  lower_data,
  input  wire logic [isa_pkg::DATA_WIDTH-1:0]  upper_data,
  output logic      [isa_pkg::DATA_WIDTH-1:0]  data
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      isa_pkg::CELL_LOAD:       data <= load_data;
      isa_pkg::CELL_FROM_LOWER: data <= lower_data;
      isa_pkg::CELL_FROM_UPPER: data <= upper_data;
      default:                  data <= data;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_shift_array.sv =====
// Top level of the indexed shift array: command decode, cell row, fill count and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel  Handshake            Payload
// -------  -------------------  -------------------------------------
// in       in_valid / in_ready  cmd, position, use_end, value_in
// out      out_valid/ out_ready value_out, count, status
//
// One item per cycle while the output is not stalled. A command is decoded
// and applied to the whole cell row in the cycle it is accepted: every shifting
// cell moves to its neighbour at once, so insert and remove are no slower than get and set.
// The result sits in an output register; a new item is taken in the same
// cycle as the pending result leaves.
// Synchronous reset clears the fill count and the output valid; cell
// contents are not reset and are only read below the fill count.
// A stall on the output holds the result and drops in_ready.

module indexed_shift_array (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   cmd,
  input  wire logic [isa_pkg::IDX_W-1:0]    position,
  input  wire logic                         use_end,
  input  wire logic [isa_pkg::VALUE_W-1:0]  value_in,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [isa_pkg::VALUE_W-1:0]  value_out,
  output logic      [isa_pkg::CNT_W-1:0]    count,
  output logic      [1:0]                   status
);

  localparam logic [isa_pkg::CNT_W-1:0] FULL_CNT = isa_pkg::CNT_W'(isa_pkg::DEPTH);

  logic                              in_fire;
  logic [isa_pkg::CNT_W-1:0]         fill;
  logic [isa_pkg::CNT_W-1:0]         fill_next;
  logic [isa_pkg::CNT_W-1:0]         idx;
  logic                              idx_ok;
  isa_pkg::status_t                  st;
  logic [isa_pkg::VALUE_W-1:0]       rd_value;
  logic [isa_pkg::DATA_WIDTH-1:0]    store_value;

  isa_pkg::cell_ctrl_t               cell_ctrl [isa_pkg::DEPTH];
  logic [isa_pkg::DATA_WIDTH-1:0]    cell_data [isa_pkg::DEPTH];

  assign in_ready    = !out_valid || out_ready;
  assign in_fire     = in_valid && in_ready;
  assign store_value = isa_pkg::DATA_WIDTH'(value_in);

  // Index resolution and status. At-end means append for insert and the
  // last entry otherwise; an empty array has no last entry.
  always_comb begin
    idx    = '0;
    idx_ok = 1'b0;
    st     = isa_pkg::ST_OK;
    if (cmd == isa_pkg::CMD_INSERT) begin
      idx = use_end ? fill : isa_pkg::CNT_W'(position);
      if (idx > fill) begin
        st = isa_pkg::ST_RANGE;
      end else if (fill == FULL_CNT) begin
        st = isa_pkg::ST_FULL;
      end else begin
        idx_ok = 1'b1;
      end
    end else begin
      if (use_end) begin
        idx    = fill - 1'b1;
        idx_ok = (fill != '0);
      end else begin
        idx    = isa_pkg::CNT_W'(position);
        idx_ok = (isa_pkg::CNT_W'(position) < fill);
      end
      if (!idx_ok) begin
        st = isa_pkg::ST_RANGE;
      end
    end
  end

  // Per-cell control: insert shifts cells above the index up, remove pulls
  // cells from the index onwards down. Cells beyond the fill count may take
  // junk; they are never read.
  always_comb begin
    fill_next = fill;
    rd_value  = '0;
    for (int i = 0; i < isa_pkg::DEPTH; i++) begin
      cell_ctrl[i].op = isa_pkg::CELL_HOLD;
    end
    if (in_fire && idx_ok) begin
      case (cmd)
        isa_pkg::CMD_INSERT: begin
          fill_next = fill + 1'b1;
          for (int i = 0; i < isa_pkg::DEPTH; i++) begin
            if (isa_pkg::CNT_W'(i) > idx) begin
              cell_ctrl[i].op = isa_pkg::CELL_FROM_LOWER;
            end else if (isa_pkg::CNT_W'(i) == idx) begin
              cell_ctrl[i].op = isa_pkg::CELL_LOAD;
            end
          end
        end
        isa_pkg::CMD_REMOVE: begin
          fill_next = fill - 1'b1;
          for (int i = 0; i < isa_pkg::DEPTH; i++) begin
            if (isa_pkg::CNT_W'(i) >= idx) begin
              cell_ctrl[i].op = isa_pkg::CELL_FROM_UPPER;
            end
          end
        end
        isa_pkg::CMD_GET: begin
          rd_value = isa_pkg::VALUE_W'(cell_data[idx[isa_pkg::IDX_W-1:0]]);
        end
        isa_pkg::CMD_SET: begin
          for (int i = 0; i < isa_pkg::DEPTH; i++) begin
            if (isa_pkg::CNT_W'(i) == idx) begin
              cell_ctrl[i].op = isa_pkg::CELL_LOAD;
            end
          end
        end
        default: begin
          fill_next = fill;
        end
      endcase
    end
  end

  // The cell row. Ends of the chain feed the incoming word at the bottom and
  // the top cell's own word at the top; neither path is selected in use
  // except for the top cell on remove, where its word is past the new fill.
  for (genvar g = 0; g < isa_pkg::DEPTH; g++) begin : g_cell
    logic [isa_pkg::DATA_WIDTH-1:0] lower;
    logic [isa_pkg::DATA_WIDTH-1:0] upper;
    if (g == 0) begin : g_bottom
      assign lower = store_value;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == isa_pkg::DEPTH - 1) begin : g_top
      assign upper = cell_data[g];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    isa_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .load_data  (store_value),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[g])
    );
  end

  // Fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_out <= rd_value;
      count     <= fill_next;
      status    <= st;
    end
  end

  // Checks on the array's own bookkeeping.
  `ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill <= FULL_CNT)
  `ASSERT_NEXT(a_err_keeps_fill, clk, rst, in_fire && !idx_ok, fill == $past(fill))
  `ASSERT_NEXT(a_idle_keeps_fill, clk, rst, !in_fire, $stable(fill))
  `ASSERT_IMPLIES(a_err_zero_value, clk, rst, out_valid && status != isa_pkg::ST_OK,
                  value_out == '0)

endmodule

`default_nettype wire

// ===== tb/tb_indexed_shift_array.sv =====
// Testbench for indexed_shift_array: random and directed commands checked against a predictor.
`timescale 1ns / 1ps

module tb_indexed_shift_array;
  import isa_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int PHASE_ITEMS  = 335;   // random items per idling phase
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 8;     // extra cycles before the final check

  // What one result item should carry.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   count;
    status_t            status;
  } array_result_t;

  // Shadow copy of the array plus the queue of results still owed by the block.
  class array_scoreboard;
    logic [DATA_WIDTH-1:0] cells [DEPTH];
    int unsigned           fill;
    array_result_t         expected_q [$];
    int unsigned           mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted command to the shadow array and queue its result.
    function void note_command(cmd_t op, logic [IDX_W-1:0] pos, logic at_end,
                               logic [VALUE_W-1:0] din);
      array_result_t res;
      int unsigned   idx;
      int unsigned   i;
      bit            in_range;
      res.value  = '0;
      res.status = ST_OK;
      if (op == CMD_INSERT) begin
        // append lands at index fill; a full array is only reported once the index is good
        idx = at_end ? fill : pos;
        if (idx > fill) begin
          res.status = ST_RANGE;
        end else if (fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = fill; i > idx; i--) cells[i] = cells[i-1];
          cells[idx] = din[DATA_WIDTH-1:0];
          fill++;
        end
      end else begin
        // at-end on an empty array has no last entry, so it is out of range
        in_range = at_end ? (fill > 0) : (pos < fill);
        idx      = at_end ? ((fill > 0) ? fill - 1 : 0) : pos;
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          case (op)
            CMD_REMOVE: begin
              for (i = idx; i + 1 < fill; i++) cells[i] = cells[i+1];
              fill--;
            end
            CMD_GET: begin
              res.value = VALUE_W'(cells[idx]);
            end
            default: begin
              cells[idx] = din[DATA_WIDTH-1:0];
            end
          endcase
        end
      end
      res.count = CNT_W'(fill);
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [VALUE_W-1:0] vo, logic [CNT_W-1:0] cnt,
                               logic [1:0] st);
      array_result_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: value %h count %0d status %0d",
                 $time, vo, cnt, st);
        return;
      end
      exp_res = expected_q.pop_front();
      if (vo !== exp_res.value) begin
        mismatches++;
        $display("%0t: value_out expected %h, got %h", $time, exp_res.value, vo);
      end
      if (cnt !== exp_res.count) begin
        mismatches++;
        $display("%0t: count expected %0d, got %0d", $time, exp_res.count, cnt);
      end
      if (st !== exp_res.status) begin
        mismatches++;
        $display("%0t: status expected %0d, got %0d", $time, exp_res.status, st);
      end
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  cmd_t                 in_cmd      = CMD_INSERT;
  logic [IDX_W-1:0]     in_position = '0;
  logic                 in_use_end  = 1'b0;
  logic [VALUE_W-1:0]   in_value    = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [VALUE_W-1:0]   value_out;
  logic [CNT_W-1:0]     count;
  logic [1:0]           status;

  array_scoreboard      sb = new();
  int unsigned          idle_pct    = 0;   // chance the sender skips a cycle
  int unsigned          stall_pct   = 0;   // chance the receiver holds off
  int unsigned          quiet_cycles = 0;
  bit                   growing     = 1'b1; // random mix leans to inserts while set

  indexed_shift_array i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (in_cmd),
    .position  (in_position),
    .use_end   (in_use_end),
    .value_in  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .count     (count),
    .status    (status)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver: ready is redrawn every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels are sampled at the rising edge; the input is noted first so
  // that ordering holds even if the result came out in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_command(in_cmd, in_position, in_use_end, in_value);
      if (out_valid && out_ready)
        sb.check_result(value_out, count, status);
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side is a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one item; called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_command(cmd_t op, logic [IDX_W-1:0] pos, logic at_end,
                              logic [VALUE_W-1:0] din);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= op;
    in_position <= pos;
    in_use_end  <= at_end;
    in_value    <= din;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed commands against the current fill, with some stray indices.
  task automatic send_random();
    cmd_t               op;
    logic [IDX_W-1:0]   pos;
    logic               at_end;
    logic [VALUE_W-1:0] din;
    int unsigned        r;
    int unsigned        fill_now;
    int unsigned        ins_pct;
    int unsigned        rem_pct;
    fill_now = sb.fill;
    // turn round at the ends so the fill sweeps empty to full and back
    if (fill_now == DEPTH && $urandom_range(3) == 0)
      growing = 1'b0;
    else if (fill_now == 0)
      growing = 1'b1;
    else if ($urandom_range(49) == 0)
      growing = !growing;
    ins_pct = growing ? 60 : 20;
    rem_pct = growing ? 15 : 50;
    r = $urandom_range(99);
    if (r < ins_pct)
      op = CMD_INSERT;
    else if (r < ins_pct + rem_pct)
      op = CMD_REMOVE;
    else if (r[0])
      op = CMD_GET;
    else
      op = CMD_SET;
    at_end = ($urandom_range(3) == 0);
    if ($urandom_range(99) < 15)
      pos = IDX_W'($urandom_range(DEPTH - 1));
    else if (op == CMD_INSERT)
      pos = IDX_W'($urandom_range((fill_now < DEPTH - 1) ? fill_now : DEPTH - 1));
    else
      pos = (fill_now == 0) ? '0 : IDX_W'($urandom_range(fill_now - 1));
    case ($urandom_range(7))
      0:       din = '0;
      1:       din = '1;
      default: din = $urandom;
    endcase
    send_command(op, pos, at_end, din);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: commands on an empty array, then a small array built and partly torn down.
    send_command(CMD_GET,    4'd0,  1'b1, 32'h0);
    send_command(CMD_REMOVE, 4'd0,  1'b1, 32'h0);
    send_command(CMD_SET,    4'd0,  1'b1, 32'h11111111);
    send_command(CMD_GET,    4'd0,  1'b0, 32'h0);
    send_command(CMD_INSERT, 4'd3,  1'b0, 32'hCAFEF00D);   // past the end
    send_command(CMD_INSERT, 4'd9,  1'b1, 32'hFFFFFFFF);   // append, position ignored
    send_command(CMD_INSERT, 4'd0,  1'b0, 32'h00000000);   // at the front
    send_command(CMD_INSERT, 4'd1,  1'b0, 32'hA5A5A5A5);   // in the middle
    send_command(CMD_INSERT, 4'd3,  1'b0, 32'h5A5A5A5A);   // index equal to fill
    send_command(CMD_INSERT, 4'd5,  1'b0, 32'h0F0F0F0F);
    send_command(CMD_GET,    4'd0,  1'b0, 32'h0);
    send_command(CMD_GET,    4'd3,  1'b0, 32'h0);
    send_command(CMD_GET,    4'd15, 1'b1, 32'h0);
    send_command(CMD_GET,    4'd4,  1'b0, 32'h0);           // one past the last entry
    send_command(CMD_SET,    4'd2,  1'b0, 32'h12345678);
    send_command(CMD_SET,    4'd0,  1'b1, 32'hDEADBEEF);
    send_command(CMD_SET,    4'd15, 1'b0, 32'h87654321);
    send_command(CMD_GET,    4'd2,  1'b0, 32'h0);
    send_command(CMD_REMOVE, 4'd0,  1'b0, 32'h0);
    send_command(CMD_REMOVE, 4'd7,  1'b1, 32'h0);
    send_command(CMD_REMOVE, 4'd1,  1'b0, 32'h0);
    send_command(CMD_REMOVE, 4'd9,  1'b0, 32'h0);

    // Random phases: no idling, sender gaps, receiver stalls, then a light mix.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat (PHASE_ITEMS) send_random();
      // hold the sender off until every result of the phase is back
      in_valid <= 1'b0;
      @(negedge clk);
      while (sb.expected_q.size() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
